### rtl/bf3_pkg.sv
// Package for the 3x3 box filter: word types, register indexes, divide table.
// No dependencies.
`default_nettype none
package bf3_pkg;
    localparam int unsigned REG_W = 11;
    localparam logic [0:0] REG_WIDTH  = 1'b0;
    localparam logic [0:0] REG_HEIGHT = 1'b1;
    localparam logic [10:0] HEIGHT_LIMIT = 11'd1024;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic       flush;
    } t_in_word;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       end_of_frame;
    } t_out_word;

    // classified job passed from front to back
    typedef struct packed {
        logic [23:0] pix;
        logic [23:0] up;
        logic [23:0] mid;
        logic        x0;
        logic        emit;
        logic        last;
        logic        row_lo;   // row cy-1 in image
        logic        row_hi;   // row cy+1 in image
        logic        col_lo;   // column cx-1 in image
        logic        col_hi;   // column cx+1 in image
    } t_job;

    // reciprocal for sum/cnt, cnt one of 1,2,3,4,6,9: q = (s*recip)>>16, s <= 2295
    function automatic logic [16:0] recip(input logic [3:0] c);
        logic [16:0] r;
        case (c)
            4'd1: r = 17'd65536;
            4'd2: r = 17'd32768;
            4'd3: r = 17'd21846;
            4'd4: r = 17'd16384;
            4'd6: r = 17'd10923;
            4'd9: r = 17'd7282;
            default: r = 17'd65536;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

### rtl/bf3_front.sv
// Front end: position counters, line buffers, border classification.
// Depends on bf3_pkg.
`default_nettype none
module bf3_front import bf3_pkg::*; #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [10:0] i_w,
    input  wire logic [10:0] i_h,
    input  wire logic        i_valid,
    input  wire t_in_word    i_word,
    output logic             o_ready,
    output logic             o_job_valid,
    output t_job             o_job,
    input  wire logic        i_job_ready
);
    localparam int AW = $clog2(MAX_WIDTH);
    localparam logic [12:0] MAXW = 13'(MAX_WIDTH);

    logic [23:0] upper_mem [MAX_WIDTH];
    logic [23:0] middle_mem [MAX_WIDTH];
    logic [10:0] r_col, r_row;
    // stage A: address resolved, line buffer read data registered
    logic        r_a_vld;
    logic [10:0] r_a_x, r_a_y;
    logic [23:0] r_a_pix;
    logic [23:0] r_up, r_mid;
    logic [10:0] n_col, n_row;
    logic [11:0] w12, h12;
    logic [11:0] wc;
    logic [10:0] x, y, xs, ys;
    logic [AW-1:0] rd_addr, wr_addr;
    logic        stall;
    t_job        job;

    assign wc  = (i_w == 11'd0) ? 12'd1 : ((13'(i_w) > MAXW) ? 12'(MAXW) : 12'(i_w));
    assign w12 = wc;
    assign h12 = (i_h == 11'd0) ? 12'd1 :
                 ((i_h > HEIGHT_LIMIT) ? 12'(HEIGHT_LIMIT) : 12'(i_h));

    always_comb begin
        xs = r_col; ys = r_row;
        if (12'(xs) >= w12) begin xs = 11'd0; ys = ys + 11'd1; end
        if (12'(ys) > h12 + 12'd1 || (12'(ys) == h12 + 12'd1 && xs != 11'd0)) begin
            xs = 11'd0; ys = 11'd0;
        end
        x = xs; y = ys;
    end

    assign rd_addr = AW'(x);
    assign wr_addr = AW'(r_a_x);

    // job classification from stage A
    logic signed [12:0] cy, cx;
    always_comb begin
        if (r_a_x != 11'd0) begin
            cy = 13'(r_a_y) - 13'sd1; cx = 13'(r_a_x) - 13'sd1;
        end else begin
            cy = 13'(r_a_y) - 13'sd2; cx = 13'(w12) - 13'sd1;
        end
        job.pix    = r_a_pix;
        job.up     = r_up;
        job.mid    = r_mid;
        job.x0     = (r_a_x == 11'd0);
        job.emit   = (cy >= 0) && (cy < 13'(h12));
        job.last   = (cy == 13'(h12) - 13'sd1) && (cx == 13'(w12) - 13'sd1);
        job.row_lo = (cy >= 13'sd1);
        job.row_hi = (cy + 13'sd1 < 13'(h12));
        job.col_lo = (cx >= 13'sd1);
        job.col_hi = (cx + 13'sd1 < 13'(w12));
    end

    assign stall       = r_a_vld && !i_job_ready;
    assign o_ready     = !stall;
    assign o_job_valid = r_a_vld;
    assign o_job       = job;

    // next position after this word
    always_comb begin
        n_col = x + 11'd1; n_row = y;
        if (12'(n_col) >= w12) begin n_col = 11'd0; n_row = y + 11'd1; end
    end

    // writes lag reads by one word; when the word in stage A is written to
    // the column being read (width one, or a frame restart at column 0),
    // forward its write data instead of the stale array entry
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            if (r_a_vld && i_job_ready && r_a_x == x) begin
                r_up  <= r_mid;
                r_mid <= r_a_pix;
            end else begin
                r_up  <= upper_mem[rd_addr];
                r_mid <= middle_mem[rd_addr];
            end
            r_a_x <= x; r_a_y <= y;
            r_a_pix <= i_word.flush ? 24'd0 :
                       {i_word.blue_in, i_word.green_in, i_word.red_in};
        end
        if (r_a_vld && i_job_ready) begin
            upper_mem[wr_addr]  <= r_mid;
            middle_mem[wr_addr] <= r_a_pix;
        end
    end

    // a word accepted while the last word leaves stage A already wrapped to
    // the frame start, so its next position wins over the restart
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0; r_col <= '0; r_row <= '0;
        end else begin
            if (!stall) r_a_vld <= i_valid;
            if (i_valid && o_ready) begin
                r_col <= n_col; r_row <= n_row;
            end else if (r_a_vld && i_job_ready && job.last) begin
                r_col <= '0; r_row <= '0;
            end
        end
    end
endmodule
`default_nettype wire

### rtl/bf3_back.sv
// Back end: 3x3 window, masked sums, reciprocal divide, result queue.
// Depends on bf3_pkg.
`default_nettype none
module bf3_back import bf3_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_job_valid,
    input  wire t_job  i_job,
    output logic       o_job_ready,
    output logic       o_empty,
    output t_out_word  o_word,
    input  wire logic  i_pop
);
    logic [23:0] r_win [6];
    logic        r_b_vld;
    logic [11:0] r_sum [3];
    logic [3:0]  r_cnt;
    logic        r_b_last;
    logic [1:0]  r_fill;
    t_out_word   r_q [2];
    logic        r_head;
    logic [11:0] sum [3];
    logic [3:0]  cnt;
    logic [23:0] col [3];
    logic [28:0] prod [3];
    logic        rowok [3], colok [3];
    logic        take;

    assign col[0] = i_job.up; assign col[1] = i_job.mid; assign col[2] = i_job.pix;
    assign rowok[0] = i_job.row_lo; assign rowok[1] = 1'b1; assign rowok[2] = i_job.row_hi;
    assign colok[0] = i_job.col_lo; assign colok[1] = 1'b1;
    assign colok[2] = i_job.col_hi && !i_job.x0;

    always_comb begin
        cnt = 4'd0;
        for (int k = 0; k < 3; k++) sum[k] = 12'd0;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                if (rowok[r] && colok[c]) begin
                    cnt = cnt + 4'd1;
                    for (int k = 0; k < 3; k++)
                        sum[k] = sum[k] + 12'((c == 2) ? col[r][8*k +: 8]
                                                        : r_win[r*2+c][8*k +: 8]);
                end
            end
        end
        if (cnt == 4'd0) cnt = 4'd1;
    end

    // room for the word in flight plus the queue
    assign o_job_ready = (r_fill == 2'd0) || (r_fill == 2'd1 && !r_b_vld);
    assign take = i_job_valid && o_job_ready;

    always_comb
        for (int k = 0; k < 3; k++) prod[k] = 29'(r_sum[k] * recip(r_cnt));

    // tail slot is head + fill; a pop in the same cycle does not move it
    always_ff @(posedge i_clk) begin
        if (take) begin
            for (int k = 0; k < 3; k++) r_sum[k] <= sum[k];
            r_cnt <= cnt; r_b_last <= i_job.last;
        end
        if (r_b_vld)
            r_q[r_head ^ r_fill[0]] <=
                '{red_out: prod[0][23:16], green_out: prod[1][23:16],
                  blue_out: prod[2][23:16], end_of_frame: r_b_last};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0; r_fill <= '0; r_head <= 1'b0;
            for (int i = 0; i < 6; i++) r_win[i] <= '0;
        end else begin
            if (take) begin
                for (int r = 0; r < 3; r++) begin
                    r_win[r*2]   <= r_win[r*2+1];
                    r_win[r*2+1] <= col[r];
                end
            end
            r_b_vld <= take && i_job.emit;
            if (i_pop && !o_empty) r_head <= ~r_head;
            r_fill <= r_fill + 2'(r_b_vld) - 2'(i_pop && !o_empty);
        end
    end

    assign o_empty = (r_fill == 2'd0);
    assign o_word  = r_q[r_head];

    a_fill_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= 2'd2)
        else $error("queue overflow");
    a_cnt_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_vld |-> r_cnt != 4'd0)
        else $error("zero count");
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_vld |-> (r_fill != 2'd2 || (i_pop && !o_empty)))
        else $error("result dropped");
endmodule
`default_nettype wire

### rtl/box_filter_3x3_core.sv
// Top level of the streaming 3x3 RGB box filter.
// Depends on bf3_pkg, bf3_front, bf3_back.
`default_nettype none
// Takes one pixel word per push in raster order and returns the truncated
// mean of each pixel's in-image 3x3 neighborhood, one row and one pixel late.
// After the frame's last pixel send image_width+1 flush words; the result of
// the last pixel carries end_of_frame. A word is accepted into the front's
// line buffer read stage, moves on to the back's registered window sum, and
// its result is written into the two-entry result queue after the reciprocal
// multiply, from where it can be popped. The back takes a new job only while
// the queue has room for it and for the result already in flight, so a
// steady stream stalls now and then even with pop held high; full rises when
// that room is missing while a word waits in the front's read stage.
// Geometry must be written only while idle; the user is bound by this, as
// the block itself does not enforce it.
module box_filter_3x3_core import bf3_pkg::*; #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire t_in_word    i_word,
    output logic             empty,
    input  wire logic        pop,
    output t_out_word        o_word,
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_idx,
    input  wire logic [10:0] i_cfg_data
);
    logic [10:0] r_w, r_h;
    logic        rdy, jv, jr;
    t_job        job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= 11'd640; r_h <= 11'd640;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_WIDTH:  r_w <= i_cfg_data;
                REG_HEIGHT: r_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign full = !rdy;

    bf3_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .i_clk, .i_rst_n, .i_w(r_w), .i_h(r_h), .i_valid(push), .i_word,
        .o_ready(rdy), .o_job_valid(jv), .o_job(job), .i_job_ready(jr));

    bf3_back u_back (
        .i_clk, .i_rst_n, .i_job_valid(jv), .i_job(job), .o_job_ready(jr),
        .o_empty(empty), .o_word, .i_pop(pop));
endmodule
`default_nettype wire
